// ----- rtl/core/clock_page_replacement_unit_macros.svh -----
// ----------------------------------------------------------------------------
// clock page replacement unit assertion macros
// shared concurrent assertion forms, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define CRPU_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CRPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CRPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CRPU_ASSERT(label, clk, rst_n, cond, msg)
`define CRPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CRPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/crpu_pkg.sv -----
// ----------------------------------------------------------------------------
// crpu_pkg
// constants, types and sequencer states of the clock page replacement unit
// ----------------------------------------------------------------------------
package crpu_pkg;

    // sizing
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 20;
    localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);

    // fixed field widths
    localparam int CFG_W   = 5;
    localparam int INDEX_W = 4;
    localparam int TOTAL_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    // page table memory access
    typedef struct packed {
        logic                 rd_en;
        logic [FRAME_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [FRAME_W-1:0]   wr_addr;
        logic [PAGE_BITS-1:0] wr_data;
    } t_ram_req;

    // one result item
    typedef struct packed {
        logic               fault;
        logic [INDEX_W-1:0] frame_index;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] fault_total;
    } t_result;

endpackage

// ----- rtl/core/crpu_page_ram.sv -----
// ----------------------------------------------------------------------------
// crpu_page_ram
// page number per frame, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module crpu_page_ram (
    input  logic                           i_clk,
    input  crpu_pkg::t_ram_req             i_req,
    output logic [crpu_pkg::PAGE_BITS-1:0] o_rd_data
);

    logic [crpu_pkg::PAGE_BITS-1:0] mem [crpu_pkg::FRAMES];
    logic [crpu_pkg::PAGE_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/crpu_ctrl.sv -----
// ----------------------------------------------------------------------------
// crpu_ctrl
// lookup scan, empty frame fill and clock sweep sequencer with frame flags
// ----------------------------------------------------------------------------
`include "clock_page_replacement_unit_macros.svh"

module crpu_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [crpu_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [crpu_pkg::PAGE_BITS-1:0] i_page_number,
    output crpu_pkg::t_ram_req             o_ram_req,
    input  logic [crpu_pkg::PAGE_BITS-1:0] i_ram_rd_data,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output crpu_pkg::t_result              o_res
);

    localparam int FW = crpu_pkg::FRAME_W;
    localparam int CW = crpu_pkg::CNT_W;
    localparam int TW = crpu_pkg::TOTAL_W;

    // control state
    crpu_pkg::t_state             r_state, n_state;
    logic [crpu_pkg::CFG_W-1:0]   r_cfg;
    logic [crpu_pkg::FRAMES-1:0]  r_valid, n_valid;
    logic [crpu_pkg::FRAMES-1:0]  r_ref, n_ref;
    logic [FW-1:0]                r_hand, n_hand;
    logic [TW-1:0]                r_hit_cnt, n_hit_cnt;
    logic [TW-1:0]                r_fault_cnt, n_fault_cnt;
    logic [CW-1:0]                r_scan, n_scan;
    logic                         r_cmp_vld, n_cmp_vld;

    // payload
    logic [crpu_pkg::PAGE_BITS-1:0] r_page, n_page;
    logic [FW-1:0]                  r_cmp_idx, n_cmp_idx;
    logic [FW-1:0]                  r_hand_cur, n_hand_cur;
    logic [FW-1:0]                  r_used, n_used;
    logic                           r_fault, n_fault;

    logic [CW-1:0]      act_frames;
    logic               empty_found;
    logic [FW-1:0]      empty_idx;
    logic               match;
    logic               scan_last;
    crpu_pkg::t_ram_req ram_req;

    // step one frame forward, wrapping at the active count
    function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f,
                                                 input logic [CW-1:0] cnt);
        if (CW'(f) + CW'(1) == cnt) begin
            return '0;
        end
        return f + FW'(1);
    endfunction

    // active frame count, clamped to one through FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            act_frames = CW'(1);
        end else if (32'(r_cfg) > crpu_pkg::FRAMES) begin
            act_frames = CW'(crpu_pkg::FRAMES);
        end else begin
            act_frames = CW'(r_cfg);
        end
    end

    // lowest invalid frame within the active count
    always_comb begin
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int f = crpu_pkg::FRAMES - 1; f >= 0; f--) begin
            if (!r_valid[f] && (CW'(f) < act_frames)) begin
                empty_found = 1'b1;
                empty_idx   = FW'(f);
            end
        end
    end

    // compare stage of the scan
    assign match     = r_cmp_vld && r_valid[r_cmp_idx] && (i_ram_rd_data == r_page);
    assign scan_last = r_cmp_vld && (CW'(r_cmp_idx) == act_frames - CW'(1));

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_ref       = r_ref;
        n_hand      = r_hand;
        n_hit_cnt   = r_hit_cnt;
        n_fault_cnt = r_fault_cnt;
        n_scan      = r_scan;
        n_cmp_vld   = 1'b0;
        n_page      = r_page;
        n_cmp_idx   = r_cmp_idx;
        n_hand_cur  = r_hand_cur;
        n_used      = r_used;
        n_fault     = r_fault;
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;
        ram_req     = '0;
        ram_req.wr_data = r_page;

        case (r_state)
            crpu_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_page  = i_page_number;
                    n_scan  = '0;
                    n_state = crpu_pkg::ST_SCAN;
                end
            end
            crpu_pkg::ST_SCAN: begin
                // issue the next frame read while comparing the last one
                if (r_scan < act_frames) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = r_scan[FW-1:0];
                    n_cmp_vld       = 1'b1;
                    n_cmp_idx       = r_scan[FW-1:0];
                    n_scan          = r_scan + CW'(1);
                end
                if (match) begin
                    n_ref[r_cmp_idx] = 1'b1;
                    if (r_hit_cnt != '1) begin
                        n_hit_cnt = r_hit_cnt + TW'(1);
                    end
                    n_used    = r_cmp_idx;
                    n_fault   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_state   = crpu_pkg::ST_RESULT;
                end else if (scan_last) begin
                    if (r_fault_cnt != '1) begin
                        n_fault_cnt = r_fault_cnt + TW'(1);
                    end
                    n_fault   = 1'b1;
                    n_cmp_vld = 1'b0;
                    if (empty_found) begin
                        ram_req.wr_en      = 1'b1;
                        ram_req.wr_addr    = empty_idx;
                        n_valid[empty_idx] = 1'b1;
                        n_ref[empty_idx]   = 1'b1;
                        n_used             = empty_idx;
                        n_state            = crpu_pkg::ST_RESULT;
                    end else begin
                        n_hand_cur = (CW'(r_hand) >= act_frames) ? '0 : r_hand;
                        n_state    = crpu_pkg::ST_SWEEP;
                    end
                end
            end
            crpu_pkg::ST_SWEEP: begin
                // second chance: clear set bits until a clear one is met
                if (!r_ref[r_hand_cur]) begin
                    ram_req.wr_en       = 1'b1;
                    ram_req.wr_addr     = r_hand_cur;
                    n_valid[r_hand_cur] = 1'b1;
                    n_ref[r_hand_cur]   = 1'b1;
                    n_used              = r_hand_cur;
                    n_hand              = next_frame(r_hand_cur, act_frames);
                    n_state             = crpu_pkg::ST_RESULT;
                end else begin
                    n_ref[r_hand_cur] = 1'b0;
                    n_hand_cur        = next_frame(r_hand_cur, act_frames);
                end
            end
            crpu_pkg::ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = crpu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = crpu_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crpu_pkg::ST_IDLE;
            r_cfg       <= crpu_pkg::CFG_RESET;
            r_valid     <= '0;
            r_ref       <= '0;
            r_hand      <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_scan      <= '0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_ref       <= n_ref;
            r_hand      <= n_hand;
            r_hit_cnt   <= n_hit_cnt;
            r_fault_cnt <= n_fault_cnt;
            r_scan      <= n_scan;
            r_cmp_vld   <= n_cmp_vld;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_cmp_idx  <= n_cmp_idx;
        r_hand_cur <= n_hand_cur;
        r_used     <= n_used;
        r_fault    <= n_fault;
    end

    assign o_ram_req = ram_req;

    // result fields
    always_comb begin
        o_res.fault       = r_fault;
        o_res.frame_index = crpu_pkg::INDEX_W'(r_used);
        o_res.hit_total   = r_hit_cnt;
        o_res.fault_total = r_fault_cnt;
    end

    // checks
    `CRPU_ASSERT(a_no_rd_wr_overlap, i_clk, i_rst_n,
        !(ram_req.rd_en && ram_req.wr_en), "page ram read and write in one cycle")
    `CRPU_ASSERT_IMP(a_cmp_in_range, i_clk, i_rst_n,
        (r_state == crpu_pkg::ST_SCAN) && r_cmp_vld, CW'(r_cmp_idx) < act_frames,
        "compare index beyond active frames")
    `CRPU_ASSERT_NXT(a_loaded_frame_flags, i_clk, i_rst_n,
        (r_state != crpu_pkg::ST_RESULT) && (n_state == crpu_pkg::ST_RESULT),
        r_valid[r_used] && r_ref[r_used], "used frame not valid and referenced")
    `CRPU_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n,
        r_state == crpu_pkg::ST_IDLE, !ram_req.wr_en && !o_res_valid,
        "write or result while idle")

endmodule

// ----- rtl/core/clock_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// second-chance page replacement over a small physical frame table
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one page reference per
//   transfer; output channel: o_out_valid / i_out_stall carry one result
//   (fault flag, frame index, saturating hit and fault totals) per reference.
//   i_cfg_wr_en / i_cfg_wr_data write frames_in_use; the user must write it
//   only while the block is idle, which the block itself leaves unenforced.
// the scan reads the active frames in order until the page is found; a miss
// fills the lowest free frame or, with a full table, sweeps from the hand,
// clearing set reference bits until a clear one is met; one reference is
// worked on at a time, and the next reference is taken in the cycle after
// the result is loaded
// the frame scan reads one page table entry per cycle from the single
// read port of the page memory; the sweep visits one reference bit per cycle
// reset clears all frame flags, the hand, both totals and sets the frame
// count to 16; the page memory needs no clearing
// while the receiver stalls, the finished result sits in the output register
// and the next reference is taken and worked on; it waits to be loaded
// until the output register frees up
// ----------------------------------------------------------------------------
module clock_page_replacement_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [crpu_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [crpu_pkg::PAGE_BITS-1:0]   i_page_number,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_fault,
    output logic [crpu_pkg::INDEX_W-1:0]     o_frame_index,
    output logic [crpu_pkg::TOTAL_W-1:0]     o_hit_total,
    output logic [crpu_pkg::TOTAL_W-1:0]     o_fault_total
);

    crpu_pkg::t_ram_req             ram_req;
    logic [crpu_pkg::PAGE_BITS-1:0] ram_rd_data;
    logic                           res_valid;
    logic                           res_ready;
    crpu_pkg::t_result              res;

    logic              r_out_valid, n_out_valid;
    crpu_pkg::t_result r_out;

    // page table memory
    crpu_page_ram u_page_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    // sequencer
    crpu_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_page_number (i_page_number),
        .o_ram_req     (ram_req),
        .i_ram_rd_data (ram_rd_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // output register, loads when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fault       = r_out.fault;
    assign o_frame_index = r_out.frame_index;
    assign o_hit_total   = r_out.hit_total;
    assign o_fault_total = r_out.fault_total;

endmodule
